### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the grid inflation modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i outside reset.
`define OGI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define OGI_ASSERT_NEXT(lbl, ante, cons, msg) \
  `OGI_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### rtl/core/ogi_pkg.sv
// ---------------------------------------------------------------------------
// ogi_pkg
// Types, codes and constants of the occupancy grid obstacle inflation block.
// ---------------------------------------------------------------------------
`default_nettype none

package ogi_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam int unsigned DefMaxRadius = 15;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 9;

  localparam int ProdW  = 40;
  localparam int CoordW = 26;

  localparam logic [8:0]        RstGridWidth  = 9'd256;
  localparam logic [8:0]        RstGridHeight = 9'd256;
  localparam logic [7:0]        RstScale      = 8'd10;
  localparam logic signed [7:0] RstOffsetX    = -8'sd3;
  localparam logic signed [7:0] RstOffsetY    = 8'sd3;
  localparam logic [3:0]        RstRadius     = 4'd1;

  localparam logic signed [15:0] IdLimit    = 16'sd1000;
  localparam logic signed [31:0] SpeedLimit = 32'sd3276;
  localparam logic [7:0]         Occupied   = 8'd100;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_POSITION_SCALE,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_INFLATE_RADIUS
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_RESTORE,
    KIND_OBSTACLE,
    KIND_READ
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_FILTERED,
    STAT_RANGE
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_LOAD,
    ST_COPY,
    ST_DRAIN,
    ST_SETUP,
    ST_MARK,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic latch;
    logic decode;
    logic check;
    logic load_wr;
    logic copy_rd;
    logic mark_init;
    logic mark_wr;
    logic read_rd;
    logic resp;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  ok;
    logic  copy_last;
    logic  mark_last;
    logic  out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### rtl/core/occupancy_grid_obstacle_inflate.sv
// ---------------------------------------------------------------------------
// occupancy_grid_obstacle_inflate
// Occupancy grid with original and working copies; marks a square around
// slow, tracked obstacles in the working copy.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    kind, cell_index, cell_value,
//                                                  obstacle_id, pos_x, pos_y, velocity
//   out      source     out_valid_o / out_stall_i  done_kind, read_value, marked, status
//   cfg      sink       cfg_we_i                   cfg_addr_i, cfg_wdata_i
//
// One beat at a time. After decode and check, a load writes both grids, a
// read reads the working grid, an obstacle marks one cell per cycle (up to
// 961 at radius 15), a restore copies one used cell per cycle, set by the
// single write port of the working grid. The result sits in an output
// register, so a stalled result holds up the next beat only in the response
// phase. Both grids come out of reset undefined and need no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_obstacle_inflate #(
  parameter int unsigned MAX_WIDTH  = ogi_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = ogi_pkg::DefMaxHeight,
  parameter int unsigned MAX_RADIUS = ogi_pkg::DefMaxRadius
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ogi_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [ogi_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [15:0]                   cell_index_i,
  input  logic signed [7:0]             cell_value_i,
  input  logic signed [15:0]            obstacle_id_i,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    done_kind_o,
  output logic signed [7:0]             read_value_o,
  output logic                          marked_o,
  output logic [1:0]                    status_o
);
  import ogi_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ogi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ogi_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (kind_i),
    .cell_index_i  (cell_index_i),
    .cell_value_i  (cell_value_i),
    .obstacle_id_i (obstacle_id_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .velocity_i    (velocity_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .done_kind_o   (done_kind_o),
    .read_value_o  (read_value_o),
    .marked_o      (marked_o),
    .status_o      (status_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

`default_nettype wire

### rtl/core/ogi_ctrl.sv
// ---------------------------------------------------------------------------
// ogi_ctrl
// Sequencer: takes one beat, steps the datapath through its phases and
// releases the result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ogi_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ogi_pkg::ctrl_sts_t   sts_i,
  output ogi_pkg::ctrl_cmd_t   cmd_o
);
  import ogi_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: state_d = ST_CHECK;
      ST_CHECK: begin
        unique case (sts_i.kind)
          KIND_LOAD:     state_d = ST_LOAD;
          KIND_RESTORE:  state_d = ST_COPY;
          KIND_OBSTACLE: state_d = ST_SETUP;
          KIND_READ:     state_d = ST_READ;
          default:       state_d = ST_RESP;
        endcase
      end
      ST_LOAD: state_d = ST_RESP;
      ST_COPY: begin
        if (sts_i.copy_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_RESP;
      ST_SETUP: begin
        state_d = sts_i.ok ? ST_MARK : ST_RESP;
      end
      ST_MARK: begin
        if (sts_i.mark_last) state_d = ST_RESP;
      end
      ST_READ: state_d = ST_RESP;
      ST_RESP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      ST_DECODE: cmd_o.decode    = 1'b1;
      ST_CHECK:  cmd_o.check     = 1'b1;
      ST_LOAD:   cmd_o.load_wr   = 1'b1;
      ST_COPY:   cmd_o.copy_rd   = 1'b1;
      ST_SETUP:  cmd_o.mark_init = 1'b1;
      ST_MARK:   cmd_o.mark_wr   = 1'b1;
      ST_READ:   cmd_o.read_rd   = 1'b1;
      ST_RESP:   cmd_o.resp      = sts_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `OGI_ASSERT_NEXT(a_accept_decode, state_q == ST_IDLE && in_valid_i, state_q == ST_DECODE,
                   "accepted beat did not start decode")
  `OGI_ASSERT_NEXT(a_copy_drain, state_q == ST_COPY && sts_i.copy_last, state_q == ST_DRAIN,
                   "restore sweep did not drain")
  `OGI_ASSERT_NEXT(a_mark_end, state_q == ST_MARK && sts_i.mark_last, state_q == ST_RESP,
                   "square fill overran its last cell")

endmodule

`default_nettype wire

### rtl/core/ogi_dp.sv
// ---------------------------------------------------------------------------
// ogi_dp
// Datapath: configuration registers, both grid memories, position scaling,
// square walk, restore sweep and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ogi_dp #(
  parameter int unsigned MAX_WIDTH  = ogi_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = ogi_pkg::DefMaxHeight,
  parameter int unsigned MAX_RADIUS = ogi_pkg::DefMaxRadius
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ogi_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [ogi_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [1:0]                    kind_i,
  input  logic [15:0]                   cell_index_i,
  input  logic signed [7:0]             cell_value_i,
  input  logic signed [15:0]            obstacle_id_i,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    done_kind_o,
  output logic signed [7:0]             read_value_o,
  output logic                          marked_o,
  output logic [1:0]                    status_o,
  input  ogi_pkg::ctrl_cmd_t            cmd_i,
  output ogi_pkg::ctrl_sts_t            sts_o
);
  import ogi_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = $clog2(Depth);
  localparam int UsedW = $clog2(Depth + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);

  // configuration
  logic [8:0]        gw_q, gh_q;
  logic [7:0]        scale_q;
  logic signed [7:0] offx_q, offy_q;
  logic [3:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q    <= RstGridWidth;
      gh_q    <= RstGridHeight;
      scale_q <= RstScale;
      offx_q  <= RstOffsetX;
      offy_q  <= RstOffsetY;
      rad_q   <= RstRadius;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_GRID_WIDTH:     gw_q    <= cfg_wdata_i;
        REG_GRID_HEIGHT:    gh_q    <= cfg_wdata_i;
        REG_POSITION_SCALE: scale_q <= cfg_wdata_i[7:0];
        REG_OFFSET_X:       offx_q  <= $signed(cfg_wdata_i[7:0]);
        REG_OFFSET_Y:       offy_q  <= $signed(cfg_wdata_i[7:0]);
        REG_INFLATE_RADIUS: rad_q   <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [RW-1:0] r;

  always_comb begin
    if (gw_q == '0) begin
      w = WW'(1);
    end else if (32'(gw_q) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(gw_q);
    end
    if (gh_q == '0) begin
      h = HW'(1);
    end else if (32'(gh_q) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(gh_q);
    end
    if (32'(rad_q) > MAX_RADIUS) begin
      r = RW'(MAX_RADIUS);
    end else begin
      r = RW'(rad_q);
    end
  end

  // item capture
  kind_e              kind_q;
  logic [15:0]        idx_q;
  logic [7:0]         val_q;
  logic signed [15:0] id_q;
  logic signed [31:0] px_q, py_q, vel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= kind_e'(kind_i);
      idx_q  <= cell_index_i;
      val_q  <= cell_value_i;
      id_q   <= obstacle_id_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      vel_q  <= velocity_i;
    end
  end

  // decode: magnitudes times scale, filters, cells in use
  logic [31:0]      magx, magy;
  logic [ProdW-1:0] prodx_q, prody_q;
  logic             negx_q, negy_q, idok_q, spdok_q;
  logic [UsedW-1:0] used_q;

  assign magx = px_q[31] ? 32'(-px_q) : 32'(px_q);
  assign magy = py_q[31] ? 32'(-py_q) : 32'(py_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      prodx_q <= ProdW'(magx * scale_q);
      prody_q <= ProdW'(magy * scale_q);
      negx_q  <= px_q[31];
      negy_q  <= py_q[31];
      idok_q  <= id_q < IdLimit;
      spdok_q <= (vel_q <= SpeedLimit) && (vel_q >= -SpeedLimit);
      used_q  <= UsedW'(UsedW'(w) * UsedW'(h));
    end
  end

  // check: cell coordinates, clipping and status
  logic [ProdW-17:0]         cellx, celly;
  logic signed [CoordW-1:0]  xs, ys, x, y, ws, hs, rs;
  logic signed [CoordW-1:0]  xlo, xhi, ylo, yhi, x0, x1, y0, y1;
  logic                      inx, iny, idx_ok, ok_c;
  status_e                   stat_c;

  always_comb begin
    cellx  = prodx_q[ProdW-1:16];
    celly  = prody_q[ProdW-1:16];
    xs     = negx_q ? -$signed(CoordW'(cellx)) : $signed(CoordW'(cellx));
    ys     = negy_q ? -$signed(CoordW'(celly)) : $signed(CoordW'(celly));
    x      = xs + CoordW'(offx_q);
    y      = ys + CoordW'(offy_q);
    ws     = $signed(CoordW'(w));
    hs     = $signed(CoordW'(h));
    rs     = $signed(CoordW'(r));
    inx    = !x[CoordW-1] && (x < ws);
    iny    = !y[CoordW-1] && (y < hs);
    xlo    = x - rs;
    xhi    = x + rs;
    ylo    = y - rs;
    yhi    = y + rs;
    x0     = xlo[CoordW-1] ? '0 : xlo;
    y0     = ylo[CoordW-1] ? '0 : ylo;
    x1     = (xhi > ws - CoordW'(1)) ? ws - CoordW'(1) : xhi;
    y1     = (yhi > hs - CoordW'(1)) ? hs - CoordW'(1) : yhi;
    idx_ok = 32'(idx_q) < 32'(used_q);
    case (kind_q)
      KIND_OBSTACLE: begin
        ok_c   = idok_q && spdok_q && inx && iny;
        stat_c = ok_c ? STAT_OK : STAT_FILTERED;
      end
      KIND_RESTORE: begin
        ok_c   = 1'b1;
        stat_c = STAT_OK;
      end
      default: begin
        ok_c   = idx_ok;
        stat_c = idx_ok ? STAT_OK : STAT_RANGE;
      end
    endcase
  end

  logic          ok_q;
  status_e       stat_q;
  logic [XW-1:0] x0_q, x1_q, cx_q;
  logic [YW-1:0] y0_q, y1_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      ok_q   <= ok_c;
      stat_q <= stat_c;
      x0_q   <= XW'(x0);
      x1_q   <= XW'(x1);
      y0_q   <= YW'(y0);
      y1_q   <= YW'(y1);
    end
  end

  // square walk: one cell per cycle, row base advanced by the width
  logic [AddrW-1:0] row_q, mark_addr;

  assign mark_addr = row_q + AddrW'(cx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_init) begin
      row_q <= AddrW'(AddrW'(y0_q) * AddrW'(w));
      cx_q  <= x0_q;
      cy_q  <= y0_q;
    end else if (cmd_i.mark_wr) begin
      if (cx_q == x1_q) begin
        cx_q  <= x0_q;
        cy_q  <= cy_q + YW'(1);
        row_q <= row_q + AddrW'(w);
      end else begin
        cx_q  <= cx_q + XW'(1);
      end
    end
  end

  // restore sweep: read original, write working in the following cycle
  logic [AddrW-1:0] ptr_q, cp_addr_q;
  logic [7:0]       orig_rd_q, wrk_rd_q;
  logic             pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.copy_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      ptr_q <= '0;
    end else if (cmd_i.copy_rd) begin
      ptr_q     <= ptr_q + AddrW'(1);
      cp_addr_q <= ptr_q;
    end
  end

  // grid memories
  logic [7:0] orig_mem [Depth];
  logic [7:0] wrk_mem  [Depth];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && ok_q) begin
      orig_mem[AddrW'(idx_q)] <= val_q;
    end
    if (cmd_i.copy_rd) begin
      orig_rd_q <= orig_mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && ok_q) begin
      wrk_mem[AddrW'(idx_q)] <= val_q;
    end else if (pend_q) begin
      wrk_mem[cp_addr_q] <= orig_rd_q;
    end else if (cmd_i.mark_wr) begin
      wrk_mem[mark_addr] <= Occupied;
    end
    if (cmd_i.read_rd) begin
      wrk_rd_q <= wrk_mem[AddrW'(idx_q)];
    end
  end

  // output register
  logic       out_valid_q;
  logic [1:0] done_kind_q, status_q;
  logic [7:0] read_q;
  logic       marked_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      done_kind_q <= kind_q;
      read_q      <= (kind_q == KIND_READ && ok_q) ? wrk_rd_q : 8'd0;
      marked_q    <= (kind_q == KIND_OBSTACLE) && ok_q;
      status_q    <= stat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign done_kind_o  = done_kind_q;
  assign read_value_o = $signed(read_q);
  assign marked_o     = marked_q;
  assign status_o     = status_q;

  always_comb begin
    sts_o           = '0;
    sts_o.kind      = kind_q;
    sts_o.ok        = ok_q;
    sts_o.copy_last = (32'(ptr_q) + 32'd1) == 32'(used_q);
    sts_o.mark_last = (cx_q == x1_q) && (cy_q == y1_q);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  `OGI_ASSERT(a_mark_inside, cmd_i.mark_wr |-> (cx_q <= x1_q && cy_q <= y1_q && ok_q),
              "square fill outside its clipped bounds")
  `OGI_ASSERT(a_copy_pend, pend_q |-> $past(cmd_i.copy_rd),
              "restore write without a preceding read")
  `OGI_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall_i, out_valid_q,
                   "stalled result dropped")

endmodule

`default_nettype wire

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks the occupancy grid obstacle inflation block beat by beat against a
// local grid model: directed extremes and grid limits, then randomised
// traffic over several register settings, with gaps, stalls and back
// pressure on both channels.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ogi_pkg::*;

  localparam int unsigned GridCells  = DefMaxWidth * DefMaxHeight;
  localparam int          QuietLimit = 400000;

  typedef struct packed {
    kind_e              kind;
    logic [15:0]        cell_index;
    logic signed [7:0]  cell_value;
    logic signed [15:0] obstacle_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] velocity;
  } grid_item_t;

  typedef struct packed {
    kind_e             kind;
    logic signed [7:0] read_value;
    logic              marked;
    status_e           status;
  } grid_resp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          kind_i;
  logic [15:0]         cell_index_i;
  logic signed [7:0]   cell_value_i;
  logic signed [15:0]  obstacle_id_i;
  logic signed [31:0]  pos_x_i;
  logic signed [31:0]  pos_y_i;
  logic signed [31:0]  velocity_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          done_kind_o;
  logic signed [7:0]   read_value_o;
  logic                marked_o;
  logic [1:0]          status_o;

  logic [7:0] orig_cells [GridCells];
  logic [7:0] work_cells [GridCells];
  bit         orig_known [GridCells];
  bit         work_known [GridCells];

  logic [8:0]        model_width;
  logic [8:0]        model_height;
  logic [7:0]        model_scale;
  logic signed [7:0] model_off_x;
  logic signed [7:0] model_off_y;
  logic [3:0]        model_radius;

  grid_resp_t pending_responses [$];
  int         mismatches;
  int         quiet_cycles;
  int         receiver_hold_len;
  bit         sender_gaps_on;
  bit         receiver_stalls_on;

  occupancy_grid_obstacle_inflate u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .cell_index_i  (cell_index_i),
    .cell_value_i  (cell_value_i),
    .obstacle_id_i (obstacle_id_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .velocity_i    (velocity_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .done_kind_o   (done_kind_o),
    .read_value_o  (read_value_o),
    .marked_o      (marked_o),
    .status_o      (status_o)
  );

  always #4ns clk_i = ~clk_i;

  function automatic int unsigned dim_in_use(logic [8:0] v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : 32'(v);
  endfunction

  function automatic longint scaled_cell(logic signed [31:0] pos, logic signed [7:0] offset);
    longint p;
    longint mag;
    longint cells;
    p = pos;
    mag = (p < 0) ? -p : p;
    cells = (mag * longint'(model_scale)) >> 16;
    if (p < 0) cells = -cells;
    return cells + offset;
  endfunction

  function automatic grid_resp_t predict_response(grid_item_t it);
    grid_resp_t  resp;
    int unsigned cols;
    int unsigned rows;
    int unsigned used;
    int unsigned i;
    longint      lc, lr, cx, cy, rad, speed, x0, x1, y0, y1, mx, my;
    resp.kind       = it.kind;
    resp.read_value = '0;
    resp.marked     = 1'b0;
    resp.status     = STAT_OK;
    cols = dim_in_use(model_width, DefMaxWidth);
    rows = dim_in_use(model_height, DefMaxHeight);
    used = cols * rows;
    lc = cols;
    lr = rows;
    case (it.kind)
      KIND_LOAD: begin
        if (it.cell_index < used) begin
          orig_cells[it.cell_index] = it.cell_value;
          work_cells[it.cell_index] = it.cell_value;
          orig_known[it.cell_index] = 1'b1;
          work_known[it.cell_index] = 1'b1;
        end else begin
          resp.status = STAT_RANGE;
        end
      end
      KIND_RESTORE: begin
        for (i = 0; i < used; i++) begin
          work_cells[i] = orig_cells[i];
          work_known[i] = orig_known[i];
        end
      end
      KIND_OBSTACLE: begin
        cx = scaled_cell(it.pos_x, model_off_x);
        cy = scaled_cell(it.pos_y, model_off_y);
        speed = it.velocity;
        if (speed < 0) speed = -speed;
        if (it.obstacle_id < IdLimit && speed <= SpeedLimit &&
            cx >= 0 && cx < lc && cy >= 0 && cy < lr) begin
          rad = model_radius;
          if (rad > DefMaxRadius) rad = DefMaxRadius;
          x0 = (cx - rad < 0) ? 0 : cx - rad;
          x1 = (cx + rad > lc - 1) ? lc - 1 : cx + rad;
          y0 = (cy - rad < 0) ? 0 : cy - rad;
          y1 = (cy + rad > lr - 1) ? lr - 1 : cy + rad;
          for (my = y0; my <= y1; my++) begin
            for (mx = x0; mx <= x1; mx++) begin
              work_cells[my * lc + mx] = Occupied;
              work_known[my * lc + mx] = 1'b1;
            end
          end
          resp.marked = 1'b1;
        end else begin
          resp.status = STAT_FILTERED;
        end
      end
      default: begin
        if (it.cell_index < used) resp.read_value = work_cells[it.cell_index];
        else resp.status = STAT_RANGE;
      end
    endcase
    return resp;
  endfunction

  function automatic grid_item_t random_fields();
    grid_item_t it;
    it.kind        = kind_e'($urandom_range(0, 3));
    it.cell_index  = 16'($urandom_range(0, 65535));
    it.cell_value  = 8'($urandom_range(0, 255));
    it.obstacle_id = 16'($urandom_range(0, 65535));
    it.pos_x       = $urandom;
    it.pos_y       = $urandom;
    it.velocity    = $urandom;
    return it;
  endfunction

  function automatic grid_item_t load_item(int idx, int value);
    grid_item_t it;
    it = random_fields();
    it.kind       = KIND_LOAD;
    it.cell_index = idx[15:0];
    it.cell_value = value[7:0];
    return it;
  endfunction

  function automatic grid_item_t read_item(int idx);
    grid_item_t it;
    it = random_fields();
    it.kind       = KIND_READ;
    it.cell_index = idx[15:0];
    return it;
  endfunction

  function automatic grid_item_t restore_item();
    grid_item_t it;
    it = random_fields();
    it.kind = KIND_RESTORE;
    return it;
  endfunction

  // Pick a Q16.16 position that lands on the target cell under the current scale.
  function automatic logic signed [31:0] position_for_cell(int target,
                                                           logic signed [7:0] offset);
    longint s;
    longint sc;
    longint mag;
    longint span;
    sc = model_scale;
    if (sc == 0) return $urandom;
    s = target - offset;
    span = 65536 / sc;
    mag = (((s < 0) ? -s : s) * 65536 + sc - 1) / sc + $urandom_range(0, int'(span - 1));
    if (s < 0 || (s == 0 && $urandom_range(0, 1) == 1)) mag = -mag;
    return mag[31:0];
  endfunction

  function automatic grid_item_t obstacle_at(int x, int y, int id, int vel);
    grid_item_t it;
    it = random_fields();
    it.kind        = KIND_OBSTACLE;
    it.obstacle_id = id[15:0];
    it.velocity    = vel;
    it.pos_x       = position_for_cell(x, model_off_x);
    it.pos_y       = position_for_cell(y, model_off_y);
    return it;
  endfunction

  function automatic grid_item_t random_grid_item();
    grid_item_t  it;
    int unsigned cols;
    int unsigned rows;
    int unsigned used;
    int          pick, sel, x, y, id, vel, tries;
    cols = dim_in_use(model_width, DefMaxWidth);
    rows = dim_in_use(model_height, DefMaxHeight);
    used = cols * rows;
    it = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.kind = KIND_LOAD;
      if ($urandom_range(0, 9) != 0 || used == GridCells)
        it.cell_index = 16'($urandom_range(0, used - 1));
      else
        it.cell_index = 16'($urandom_range(used, 65535));
    end else if (pick < 55) begin
      x = $urandom_range(0, cols + 1);
      y = $urandom_range(0, rows + 1);
      sel = $urandom_range(0, 19);
      if (sel < 15) id = $urandom_range(0, 999);
      else if (sel < 17) id = -int'($urandom_range(1, 32768));
      else id = $urandom_range(1000, 32767);
      sel = $urandom_range(0, 9);
      if (sel < 7) vel = int'($urandom_range(0, 6552)) - 3276;
      else if (sel == 7) vel = $urandom_range(0, 1) ? 3276 : -3276;
      else if (sel == 8) vel = $urandom_range(0, 1) ? 3277 : -3277;
      else vel = $urandom;
      it = obstacle_at(x - 1, y - 1, id, vel);
    end else if (pick < 82) begin
      it.kind = KIND_READ;
      if ($urandom_range(0, 7) == 0 && used < GridCells) begin
        it.cell_index = 16'($urandom_range(used, 65535));
      end else begin
        it.cell_index = 16'($urandom_range(0, used - 1));
        for (tries = 0; tries < 24 && !work_known[it.cell_index]; tries++)
          it.cell_index = 16'($urandom_range(0, used - 1));
      end
    end else if (pick < 88) begin
      it.kind = KIND_RESTORE;
    end
    // never read a working cell that holds no defined value
    if (it.kind == KIND_READ && it.cell_index < used && !work_known[it.cell_index])
      it.kind = KIND_LOAD;
    return it;
  endfunction

  task automatic send_item(input grid_item_t it);
    int gap;
    @(negedge clk_i);
    if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i        = it.kind;
    cell_index_i  = it.cell_index;
    cell_value_i  = it.cell_value;
    obstacle_id_i = it.obstacle_id;
    pos_x_i       = it.pos_x;
    pos_y_i       = it.pos_y;
    velocity_i    = it.velocity;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_responses.push_back(predict_response(it));
  endtask

  task automatic wait_for_responses();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e which, input int value);
    logic [8:0] data;
    data = value[8:0];
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = which;
    cfg_wdata_i = data;
    case (which)
      REG_GRID_WIDTH:     model_width  = data;
      REG_GRID_HEIGHT:    model_height = data;
      REG_POSITION_SCALE: model_scale  = data[7:0];
      REG_OFFSET_X:       model_off_x  = data[7:0];
      REG_OFFSET_Y:       model_off_y  = data[7:0];
      REG_INFLATE_RADIUS: model_radius = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic test_directed_extremes();
    grid_item_t it;
    send_item(load_item(0, -128));
    send_item(load_item(65535, 127));
    send_item(load_item(257, 5));
    send_item(read_item(0));
    send_item(read_item(65535));
    send_item(obstacle_at(0, 0, 0, 0));
    send_item(read_item(257));
    send_item(obstacle_at(255, 255, 999, 3276));
    send_item(obstacle_at(100, 100, -32768, -3276));
    send_item(obstacle_at(10, 10, 1000, 0));
    send_item(obstacle_at(10, 10, 32767, 0));
    send_item(obstacle_at(10, 10, 5, 3277));
    send_item(obstacle_at(10, 10, 5, -3277));
    send_item(obstacle_at(-1, 5, 5, 0));
    send_item(obstacle_at(5, 256, 5, 0));
    it = obstacle_at(10, 10, 5, 0);
    it.pos_x    = 32'sh7FFF_FFFF;
    it.pos_y    = 32'sh8000_0000;
    it.velocity = 32'sh8000_0000;
    send_item(it);
    it = obstacle_at(10, 10, 5, 0);
    it.pos_x    = 32'sh8000_0000;
    it.pos_y    = 32'sh7FFF_FFFF;
    it.velocity = 32'sh7FFF_FFFF;
    send_item(it);
    send_item(read_item(65535));
    send_item(restore_item());
    send_item(read_item(0));
    send_item(read_item(257));
    send_item(read_item(65535));
  endtask

  task automatic test_grid_limits();
    wait_for_responses();
    write_reg(REG_GRID_WIDTH, 0);
    write_reg(REG_GRID_HEIGHT, 0);
    send_item(load_item(0, 7));
    send_item(load_item(1, -1));
    send_item(read_item(65535));
    send_item(read_item(0));
    wait_for_responses();
    write_reg(REG_POSITION_SCALE, 0);
    write_reg(REG_OFFSET_X, 0);
    write_reg(REG_OFFSET_Y, 0);
    write_reg(REG_INFLATE_RADIUS, 15);
    send_item(obstacle_at(0, 0, 1, 0));
    send_item(read_item(0));
    send_item(restore_item());
    send_item(read_item(0));
    wait_for_responses();
    write_reg(REG_OFFSET_X, -128);
    write_reg(REG_OFFSET_Y, 127);
    send_item(obstacle_at(0, 0, 1, 0));
    wait_for_responses();
    write_reg(REG_OFFSET_X, 127);
    write_reg(REG_OFFSET_Y, -128);
    send_item(obstacle_at(0, 0, 1, 0));
    wait_for_responses();
    write_reg(REG_GRID_WIDTH, 3);
    write_reg(REG_GRID_HEIGHT, 3);
    write_reg(REG_POSITION_SCALE, 1);
    write_reg(REG_OFFSET_X, 0);
    write_reg(REG_OFFSET_Y, 0);
    write_reg(REG_INFLATE_RADIUS, 0);
    send_item(load_item(1, -5));
    send_item(load_item(4, -6));
    send_item(load_item(5, -7));
    send_item(obstacle_at(1, 1, 2, 0));
    send_item(read_item(1));
    send_item(read_item(4));
    send_item(read_item(5));
    wait_for_responses();
    write_reg(REG_GRID_WIDTH, 511);
    write_reg(REG_GRID_HEIGHT, 511);
    write_reg(REG_POSITION_SCALE, 255);
    write_reg(REG_INFLATE_RADIUS, 15);
    send_item(obstacle_at(128, 128, 3, 1));
    send_item(read_item(128 * 256 + 128));
  endtask

  task automatic test_random_traffic();
    int phase, shape, cols, rows, sel;
    for (phase = 0; phase < 6; phase++) begin
      wait_for_responses();
      shape = $urandom_range(0, 3);
      cols = $urandom_range(1, 40);
      rows = $urandom_range(1, 40);
      if (shape == 2) begin
        cols = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(200, 511);
        rows = $urandom_range(0, 4);
      end else if (shape == 3) begin
        cols = $urandom_range(0, 4);
        rows = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(200, 511);
      end
      write_reg(REG_GRID_WIDTH, cols);
      write_reg(REG_GRID_HEIGHT, rows);
      sel = $urandom_range(0, 9);
      case (sel)
        0:       write_reg(REG_POSITION_SCALE, 0);
        1:       write_reg(REG_POSITION_SCALE, 1);
        2, 3:    write_reg(REG_POSITION_SCALE, 10);
        4, 5:    write_reg(REG_POSITION_SCALE, 100);
        6:       write_reg(REG_POSITION_SCALE, 255);
        default: write_reg(REG_POSITION_SCALE, $urandom_range(1, 255));
      endcase
      write_reg(REG_OFFSET_X, $urandom_range(0, 1) ?
                int'($urandom_range(0, 255)) - 128 : int'($urandom_range(0, 60)) - 30);
      write_reg(REG_OFFSET_Y, $urandom_range(0, 1) ?
                int'($urandom_range(0, 255)) - 128 : int'($urandom_range(0, 60)) - 30);
      write_reg(REG_INFLATE_RADIUS, $urandom_range(0, 15));
      repeat (140) send_item(random_grid_item());
    end
  endtask

  task automatic test_backpressure();
    wait_for_responses();
    sender_gaps_on = 1'b0;
    receiver_hold_len = 300;
    repeat (30) send_item(random_grid_item());
    wait_for_responses();
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_quiet_tail();
    sender_gaps_on = 1'b0;
    receiver_stalls_on = 1'b0;
    repeat (100) send_item(random_grid_item());
  endtask

  initial begin : receiver
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (receiver_hold_len != 0) begin
        hold_left = receiver_hold_len;
        receiver_hold_len = 0;
      end
      if (hold_left > 0) hold_left--;
      else if (burst_left > 0) burst_left--;
      else if (receiver_stalls_on && $urandom_range(0, 4) == 0) burst_left = $urandom_range(1, 3);
      out_stall_i = (hold_left > 0) || (burst_left > 0);
    end
  end

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : response_check
    grid_resp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: result expected none, actual kind %0d status %0d",
                 $time, done_kind_o, status_o);
        mismatches++;
      end else begin
        want = pending_responses.pop_front();
        check_field("done_kind", 8'(want.kind), 8'(done_kind_o));
        check_field("read_value", want.read_value, read_value_o);
        check_field("marked", 8'(want.marked), 8'(marked_o));
        check_field("status", 8'(want.status), 8'(status_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_addr_i         = REG_GRID_WIDTH;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    kind_i             = KIND_LOAD;
    cell_index_i       = '0;
    cell_value_i       = '0;
    obstacle_id_i      = '0;
    pos_x_i            = '0;
    pos_y_i            = '0;
    velocity_i         = '0;
    model_width        = RstGridWidth;
    model_height       = RstGridHeight;
    model_scale        = RstScale;
    model_off_x        = RstOffsetX;
    model_off_y        = RstOffsetY;
    model_radius       = RstRadius;
    mismatches         = 0;
    quiet_cycles       = 0;
    receiver_hold_len  = 0;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_extremes();
    test_grid_limits();
    test_random_traffic();
    test_backpressure();
    test_quiet_tail();

    wait_for_responses();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
